// ----- sv/pfd_pkg.sv -----
`timescale 1ns / 1ps
// pfd_pkg: shared types, register indexes and the power-of-ten table for
// the prime filter. No dependencies.
package pfd_pkg;

    localparam logic [1:0] CFG_DIGIT_COUNT  = 2'd0;
    localparam logic [1:0] CFG_WORKER_COUNT = 2'd1;
    localparam logic [1:0] CFG_WORKER_INDEX = 2'd2;

    typedef enum logic
    {
        DIV_SEL_RESIDUE = 1'b0,
        DIV_SEL_TRIAL   = 1'b1
    } div_sel_t;

    typedef struct packed
    {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     sq_load;
        logic     set_mine;
        logic     set_prime;
        logic     d_inc;
    } pfd_cmd_t;

    typedef struct packed
    {
        logic res_skip;
        logic div_done;
        logic n_le1;
        logic sq_gt_n;
        logic rem_zero;
    } pfd_status_t;

    function automatic logic [31:0] pow10(input logic [3:0] k);
        logic [31:0] v;
        case (k)
            4'd0:    v = 32'd1;
            4'd1:    v = 32'd10;
            4'd2:    v = 32'd100;
            4'd3:    v = 32'd1000;
            4'd4:    v = 32'd10000;
            4'd5:    v = 32'd100000;
            4'd6:    v = 32'd1000000;
            4'd7:    v = 32'd10000000;
            4'd8:    v = 32'd100000000;
            4'd9:    v = 32'd1000000000;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/prime_filter_by_digits_core.sv -----
`timescale 1ns / 1ps
// prime_filter_by_digits_core: top level of the prime filter.
// Depends on pfd_pkg, pfd_ctrl, pfd_dpath and pfd_div.
//
// Usage:
//   Input: a candidate is transferred on a rising edge with start high and
//   busy low. Busy stays high until the result has been shown.
//   Config: cfg_valid/cfg_ready write channel, cfg_index selects digit_count
//   (0), worker_count (1) or worker_index (2); cfg_ready is always high.
//   Write only while busy is low. Other indexes are ignored.
//   Result: value_out, in_range, is_mine, is_prime and selected are valid for
//   the single cycle in which done is high; the receiver cannot stall, the
//   result is taken at the edge that ends that cycle. Fields hold afterwards.
//   Sequencing: the residue check and each trial divisor run through one
//   shared bit-serial remainder unit; one item at a time, so no new
//   candidate is taken while busy is high.
//   Reset: asynchronous, active low; returns to idle with digit_count 1,
//   worker_count 1, worker_index 0. Any item in flight is dropped.
module prime_filter_by_digits_core #(
    parameter int VALUE_BITS = 30,
    parameter int MAX_DIGITS = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [29:0] candidate,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic [29:0] value_out,
    output logic        in_range,
    output logic        is_mine,
    output logic        is_prime,
    output logic        selected
);

    pfd_pkg::pfd_cmd_t    cmd;
    pfd_pkg::pfd_status_t status;
    logic                 busy_int;

    assign cfg_ready = 1'b1;
    assign busy      = busy_int;

    pfd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start & ~busy_int),
        .status (status),
        .cmd    (cmd),
        .busy   (busy_int),
        .done   (done)
    );

    pfd_dpath #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .candidate (candidate),
        .cmd       (cmd),
        .status    (status),
        .value_out (value_out),
        .in_range  (in_range),
        .is_mine   (is_mine),
        .is_prime  (is_prime),
        .selected  (selected)
    );

endmodule

// ----- sv/pfd_div.sv -----
`timescale 1ns / 1ps
// pfd_div: bit-serial restoring remainder unit, one dividend bit per cycle.
// Standalone; no package dependency.
module pfd_div #(
    parameter int N_W = 30,
    parameter int D_W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [D_W-1:0] rem
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]   r_reg;
    logic [D_W-1:0]   r_next;
    logic [N_W-1:0]   q_reg;
    logic [D_W-1:0]   dvs_reg;
    logic [D_W:0]     trial;

    always_comb
    begin
        trial = {r_reg, q_reg[N_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            r_next = D_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            r_next = trial[D_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= '0;
            q_reg   <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= {q_reg[N_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// ----- sv/pfd_dpath.sv -----
`timescale 1ns / 1ps
// pfd_dpath: config registers, candidate and flag registers, trial divisor,
// squarer and the shared remainder unit. Depends on pfd_pkg and pfd_div.
module pfd_dpath #(
    parameter int VALUE_BITS = 30,
    parameter int MAX_DIGITS = 9
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic [29:0]         candidate,
    input  pfd_pkg::pfd_cmd_t   cmd,
    output pfd_pkg::pfd_status_t status,
    output logic [29:0]         value_out,
    output logic                in_range,
    output logic                is_mine,
    output logic                is_prime,
    output logic                selected
);

    localparam int NB    = VALUE_BITS;
    localparam int DW    = (VALUE_BITS + 1) / 2 + 1;
    localparam int DIV_W = (DW > 7) ? DW : 7;
    localparam int SQ_W  = 2 * DW;

    logic [3:0]       digit_count_reg;
    logic [6:0]       worker_count_reg;
    logic [5:0]       worker_index_reg;

    logic [NB-1:0]    n_reg;
    logic [DW-1:0]    d_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic             range_reg;
    logic             mine_reg;
    logic             prime_reg;

    logic [31:0]      cand_ext;
    logic [NB-1:0]    n_in;
    logic [31:0]      n_in_ext;
    logic [31:0]      n_out_ext;
    logic [31:0]      lo;
    logic [31:0]      hi;
    logic             range_calc;
    logic [DIV_W-1:0] divisor;
    logic             div_done;
    logic [DIV_W-1:0] rem;

    assign cand_ext = 32'(candidate);
    assign n_in     = cand_ext[NB-1:0];
    assign n_in_ext = 32'(n_in);

    always_comb
    begin
        lo         = pfd_pkg::pow10(digit_count_reg - 4'd1);
        hi         = pfd_pkg::pow10(digit_count_reg) - 32'd1;
        range_calc = (digit_count_reg != 4'd0) && (digit_count_reg <= 4'(MAX_DIGITS))
                     && (n_in_ext >= lo) && (n_in_ext <= hi);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg  <= 4'd1;
            worker_count_reg <= 7'd1;
            worker_index_reg <= 6'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfd_pkg::CFG_DIGIT_COUNT:  digit_count_reg  <= cfg_data[3:0];
                pfd_pkg::CFG_WORKER_COUNT: worker_count_reg <= cfg_data;
                pfd_pkg::CFG_WORKER_INDEX: worker_index_reg <= cfg_data[5:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg     <= n_in;
            range_reg <= range_calc;
            mine_reg  <= 1'b0;
            prime_reg <= 1'b0;
            d_reg     <= DW'(2);
        end
        else
        begin
            if (cmd.set_mine)
            begin
                mine_reg <= (rem == DIV_W'(worker_index_reg));
            end
            if (cmd.set_prime)
            begin
                prime_reg <= 1'b1;
            end
            if (cmd.d_inc)
            begin
                d_reg <= d_reg + 1'b1;
            end
        end
        if (cmd.sq_load)
        begin
            sq_reg <= SQ_W'(d_reg) * SQ_W'(d_reg);
        end
    end

    assign divisor = (cmd.div_sel == pfd_pkg::DIV_SEL_TRIAL) ? DIV_W'(d_reg)
                                                             : DIV_W'(worker_count_reg);

    pfd_div #(
        .N_W (NB),
        .D_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (n_reg),
        .divisor  (divisor),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb
    begin
        status.res_skip = (worker_count_reg == 7'd0);
        status.div_done = div_done;
        status.n_le1    = (n_reg <= NB'(1));
        status.sq_gt_n  = (sq_reg > SQ_W'(n_reg));
        status.rem_zero = (rem == '0);
    end

    assign n_out_ext = 32'(n_reg);
    assign value_out = n_out_ext[29:0];
    assign in_range  = range_reg;
    assign is_mine   = mine_reg;
    assign is_prime  = prime_reg;
    assign selected  = range_reg & mine_reg & prime_reg;

endmodule

// ----- sv/pfd_ctrl.sv -----
`timescale 1ns / 1ps
// pfd_ctrl: sequencer for residue check and trial division loop.
// Depends on pfd_pkg.
module pfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  pfd_pkg::pfd_status_t status,
    output pfd_pkg::pfd_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [6:0]
    {
        ST_IDLE       = 7'b0000001,
        ST_LAUNCH     = 7'b0000010,
        ST_RES_WAIT   = 7'b0000100,
        ST_SQUARE     = 7'b0001000,
        ST_TEST       = 7'b0010000,
        ST_TRIAL_WAIT = 7'b0100000,
        ST_DONE       = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = pfd_pkg::DIV_SEL_RESIDUE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                if (status.res_skip)
                begin
                    state_next = ST_SQUARE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_RES_WAIT;
                end
            end
            ST_RES_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.set_mine = 1'b1;
                    state_next   = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.sq_load = 1'b1;
                state_next  = ST_TEST;
            end
            ST_TEST:
            begin
                if (status.n_le1)
                begin
                    state_next = ST_DONE;
                end
                else if (status.sq_gt_n)
                begin
                    cmd.set_prime = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pfd_pkg::DIV_SEL_TRIAL;
                    state_next    = ST_TRIAL_WAIT;
                end
            end
            ST_TRIAL_WAIT:
            begin
                cmd.div_sel = pfd_pkg::DIV_SEL_TRIAL;
                if (status.div_done)
                begin
                    if (status.rem_zero)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.d_inc  = 1'b1;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule
